// ===== src/dfs_pkg.sv =====
package dfs_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROOT,
		ST_TOP,
		ST_SCAN,
		ST_EDGE,
		ST_EMIT_RD,
		ST_EMIT,
		ST_CLEAR
	} dfs_state_t;

	localparam logic [1:0] COLOR_WHITE = 2'd0;
	localparam logic [1:0] COLOR_GREY  = 2'd1;
	localparam logic [1:0] COLOR_BLACK = 2'd2;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

endpackage

// ===== src/dfs_timestamps_cycle_detect.sv =====
// Depth-first search over a loaded directed graph, with discovery and finish times.
//
// Input channel (in_valid/in_ready): opcode 0 loads the edge (src_vertex, dst_vertex),
// one transfer per cycle, with no result. Opcode 1 runs the search from vertices
// 1..vertex_count in order (0 acts as 1, a count above MAX_VERTICES as MAX_VERTICES)
// and then streams one result per discovered vertex on the output channel
// (out_valid/out_ready), in discovery order, with last on the final one. acyclic is
// set on the last result when no back edge was seen; edges_dropped tells that an edge
// found the store full. A run keeps the input not ready. The search visits each root
// vertex in ST_ROOT, reloads a stack top in ST_TOP after every discovery, every edge
// followed and every finish, and reads each edge entry through ST_SCAN and ST_EDGE,
// since each vertex walks the edge memory once through its single read port, plus at
// most one read past the end. Each result then goes out through ST_EMIT_RD and
// ST_EMIT when the receiver is ready, and ST_CLEAR then clears the run state.
// The configuration channel (cfg_valid/cfg_ready) writes vertex_count; write it only
// while idle. When the receiver stalls, the current result holds until its transfer.
// Reset clears all control state; edge and time memories are undefined until written.
module dfs_timestamps_cycle_detect #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [5:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [5:0] src_vertex,
	input  logic [5:0] dst_vertex,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] vertex_id,
	output logic [6:0] discovery_time,
	output logic [6:0] finish_time,
	output logic       acyclic,
	output logic       edges_dropped,
	output logic       last
);
	import dfs_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int NW = $clog2(MAX_VERTICES + 1);

	dfs_state_t state_q, state_d;

	logic [VW-1:0] src_mem [MAX_EDGES];
	logic [VW-1:0] dst_mem [MAX_EDGES];
	logic [VW-1:0] stk_v_mem [MAX_VERTICES];
	logic [CW-1:0] stk_e_mem [MAX_VERTICES];
	logic [6:0]    disc_mem [MAX_VERTICES];
	logic [6:0]    fin_mem [MAX_VERTICES];
	logic [VW-1:0] order_mem [MAX_VERTICES];
	logic [1:0]    color_q [MAX_VERTICES];

	logic [5:0]    vcount_q;
	logic [CW-1:0] ecount_q;
	logic          ovf_q, cyc_q;
	logic [6:0]    time_q;
	logic [NW-1:0] sp_q, vis_q, root_q, k_q;
	logic [VW-1:0] u_q;
	logic [CW-1:0] e_q;
	logic [VW-1:0] rd_src_q, rd_dst_q;
	logic [NW-1:0] n_act;

	logic [VW-1:0] ov_q;
	logic [6:0]    od_q, of_q;
	logic          oval_q;

	always_comb begin
		if (vcount_q == 6'd0) n_act = NW'(1);
		else if (32'(vcount_q) > MAX_VERTICES) n_act = NW'(MAX_VERTICES);
		else n_act = NW'(vcount_q);
	end

	logic in_src_ok, in_dst_ok, load_fire, run_fire;
	assign in_src_ok = src_vertex != 6'd0 && 32'(src_vertex) <= MAX_VERTICES;
	assign in_dst_ok = dst_vertex != 6'd0 && 32'(dst_vertex) <= MAX_VERTICES;
	assign in_ready  = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign load_fire = in_valid && in_ready && opcode == OP_ADD;
	assign run_fire  = in_valid && in_ready && opcode == OP_RUN;

	logic scan_end, edge_hit;
	logic [VW-1:0] root_v;
	assign root_v   = root_q[VW-1:0];
	assign scan_end = e_q >= ecount_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (run_fire) state_d = ST_ROOT;
			ST_ROOT: begin
				if (root_q >= n_act) state_d = (vis_q == '0) ? ST_CLEAR : ST_EMIT_RD;
				else if (color_q[root_v] == COLOR_WHITE) state_d = ST_TOP;
			end
			ST_TOP:     state_d = (sp_q == '0) ? ST_ROOT : ST_SCAN;
			ST_SCAN:    state_d = ST_EDGE;
			ST_EDGE: begin
				if (scan_end) state_d = ST_TOP;
				else if (edge_hit) state_d = ST_TOP;
				else state_d = ST_SCAN;
			end
			ST_EMIT_RD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_ready) state_d = (k_q == vis_q) ? ST_CLEAR : ST_EMIT_RD;
			end
			ST_CLEAR:   state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// In ST_EDGE the registered edge read belongs to index e_q - 1.
	assign edge_hit = rd_src_q == u_q && 32'(rd_dst_q) < 32'(n_act);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		rd_src_q <= src_mem[e_q[EW-1:0]];
		rd_dst_q <= dst_mem[e_q[EW-1:0]];
		if (load_fire && in_src_ok && in_dst_ok && 32'(ecount_q) < MAX_EDGES) begin
			src_mem[ecount_q[EW-1:0]] <= VW'(src_vertex - 6'd1);
			dst_mem[ecount_q[EW-1:0]] <= VW'(dst_vertex - 6'd1);
		end
	end

	logic [NW-1:0] top_i;
	assign top_i = sp_q - NW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 6'd32;
			ecount_q <= '0;
			ovf_q <= 1'b0;
			cyc_q <= 1'b0;
			time_q <= '0;
			sp_q <= '0;
			vis_q <= '0;
			root_q <= '0;
			k_q <= '0;
			oval_q <= 1'b0;
			u_q <= '0;
			e_q <= '0;
			for (int i = 0; i < MAX_VERTICES; i++) color_q[i] <= COLOR_WHITE;
		end else begin
			if (cfg_valid && cfg_ready) vcount_q <= cfg_data;
			if (load_fire && in_src_ok && in_dst_ok) begin
				if (32'(ecount_q) < MAX_EDGES) ecount_q <= ecount_q + CW'(1);
				else ovf_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					root_q <= '0;
					k_q <= '0;
				end
				ST_ROOT: begin
					if (root_q < n_act) begin
						if (color_q[root_v] == COLOR_WHITE) begin
							time_q <= time_q + 7'd1;
							disc_mem[root_v] <= time_q + 7'd1;
							color_q[root_v] <= COLOR_GREY;
							order_mem[vis_q[VW-1:0]] <= root_v;
							vis_q <= vis_q + NW'(1);
							stk_v_mem[0] <= root_v;
							stk_e_mem[0] <= '0;
							sp_q <= NW'(1);
						end
						root_q <= root_q + NW'(1);
					end
				end
				ST_TOP: begin
					if (sp_q != '0) begin
						u_q <= stk_v_mem[top_i[VW-1:0]];
						e_q <= stk_e_mem[top_i[VW-1:0]];
					end
				end
				ST_SCAN: e_q <= e_q + CW'(1);
				ST_EDGE: begin
					if (edge_hit && !(e_q > ecount_q)) begin
						stk_e_mem[top_i[VW-1:0]] <= e_q;
						if (color_q[rd_dst_q] == COLOR_WHITE) begin
							time_q <= time_q + 7'd1;
							disc_mem[rd_dst_q] <= time_q + 7'd1;
							color_q[rd_dst_q] <= COLOR_GREY;
							order_mem[vis_q[VW-1:0]] <= rd_dst_q;
							vis_q <= vis_q + NW'(1);
							if (32'(sp_q) < MAX_VERTICES) begin
								stk_v_mem[sp_q[VW-1:0]] <= rd_dst_q;
								stk_e_mem[sp_q[VW-1:0]] <= '0;
								sp_q <= sp_q + NW'(1);
							end
						end else if (color_q[rd_dst_q] == COLOR_GREY) begin
							cyc_q <= 1'b1;
						end
					end else if (e_q > ecount_q || !edge_hit && scan_end) begin
						sp_q <= top_i;
						color_q[u_q] <= COLOR_BLACK;
						time_q <= time_q + 7'd1;
						fin_mem[u_q] <= time_q + 7'd1;
					end
				end
				ST_EMIT_RD: begin
					ov_q <= order_mem[k_q[VW-1:0]];
					od_q <= disc_mem[order_mem[k_q[VW-1:0]]];
					of_q <= fin_mem[order_mem[k_q[VW-1:0]]];
					k_q <= k_q + NW'(1);
					oval_q <= 1'b1;
				end
				ST_EMIT: begin
					if (out_ready) oval_q <= 1'b0;
				end
				ST_CLEAR: begin
					ecount_q <= '0;
					ovf_q <= 1'b0;
					cyc_q <= 1'b0;
					time_q <= '0;
					sp_q <= '0;
					vis_q <= '0;
					for (int i = 0; i < MAX_VERTICES; i++) color_q[i] <= COLOR_WHITE;
				end
				default: ;
			endcase
		end
	end

	// ST_SCAN runs before every ST_EDGE of a top, so the read of edge e is
	// registered when e_q holds e+1; scan_end above therefore means that no edge
	// remains after the one just read.
	assign out_valid      = state_q == ST_EMIT && oval_q;
	assign vertex_id      = 6'(ov_q) + 6'd1;
	assign discovery_time = od_q;
	assign finish_time    = of_q;
	assign last           = k_q == vis_q;
	assign acyclic        = last && !cyc_q;
	assign edges_dropped  = ovf_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertex_id))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("result shown while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= MAX_VERTICES)
		else $error("stack overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |=> time_q == '0 && ecount_q == '0)
		else $error("run not cleared");

endmodule

// ===== tb/dfs_search_checker.sv =====
`timescale 1ns / 1ps

module dfs_search_checker #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES    = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [5:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       opcode,
	input  logic [5:0] src_vertex,
	input  logic [5:0] dst_vertex,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [5:0] vertex_id,
	input  logic [6:0] discovery_time,
	input  logic [6:0] finish_time,
	input  logic       acyclic,
	input  logic       edges_dropped,
	input  logic       last,
	output int         mismatches,
	output int         pending
);
	import dfs_pkg::*;

	typedef struct packed {
		logic [5:0] vid;
		logic [6:0] disc;
		logic [6:0] fin;
		logic       acyc;
		logic       dropped;
		logic       lst;
	} visit_t;

	visit_t expected_visits[$];

	logic [5:0] vertex_limit;
	int         edge_from[MAX_EDGES];
	int         edge_to[MAX_EDGES];
	int         edge_num;
	logic       store_full_seen;
	int         errors;

	// Per-run search state.
	logic [1:0] color[MAX_VERTICES];
	int         disc_at[MAX_VERTICES];
	int         fin_at[MAX_VERTICES];
	int         order[MAX_VERTICES];
	int         stk_v[MAX_VERTICES];
	int         stk_e[MAX_VERTICES];
	int         sp;
	int         clock_val;
	int         visited;
	logic       back_edge_seen;

	function automatic void discover_vertex(int v);
		clock_val++;
		disc_at[v] = clock_val;
		color[v] = COLOR_GREY;
		if (visited < MAX_VERTICES) begin
			order[visited] = v;
			visited++;
		end
		if (sp < MAX_VERTICES) begin
			stk_v[sp] = v;
			stk_e[sp] = 0;
			sp++;
		end
	endfunction

	function automatic void search_graph();
		int     n;
		int     u;
		int     e;
		int     v;
		visit_t r;
		n = (vertex_limit == 0) ? 1 : int'(vertex_limit);
		if (n > MAX_VERTICES)
			n = MAX_VERTICES;
		for (int i = 0; i < MAX_VERTICES; i++)
			color[i] = COLOR_WHITE;
		sp = 0;
		clock_val = 0;
		visited = 0;
		back_edge_seen = 1'b0;
		for (int root = 0; root < n; root++) begin
			if (color[root] != COLOR_WHITE)
				continue;
			discover_vertex(root);
			while (sp > 0) begin
				u = stk_v[sp - 1];
				e = stk_e[sp - 1];
				while (e < edge_num && (edge_from[e] != u || edge_to[e] >= n))
					e++;
				if (e >= edge_num) begin
					sp--;
					color[u] = COLOR_BLACK;
					clock_val++;
					fin_at[u] = clock_val;
				end else begin
					v = edge_to[e];
					stk_e[sp - 1] = e + 1;
					if (color[v] == COLOR_WHITE)
						discover_vertex(v);
					else if (color[v] == COLOR_GREY)
						back_edge_seen = 1'b1;
				end
			end
		end
		for (int k = 0; k < visited; k++) begin
			r.vid = 6'(order[k] + 1);
			r.disc = 7'(disc_at[order[k]]);
			r.fin = 7'(fin_at[order[k]]);
			r.lst = (k + 1 == visited);
			r.acyc = r.lst && !back_edge_seen;
			r.dropped = store_full_seen;
			expected_visits.push_back(r);
		end
		edge_num = 0;
		store_full_seen = 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		visit_t want;
		if (!arst_n) begin
			vertex_limit <= 6'd32;
			edge_num = 0;
			store_full_seen = 1'b0;
			errors = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				vertex_limit <= cfg_data;
			if (in_valid && in_ready) begin
				if (opcode == OP_RUN)
					search_graph();
				else if (src_vertex >= 1 && src_vertex <= MAX_VERTICES &&
						dst_vertex >= 1 && dst_vertex <= MAX_VERTICES) begin
					if (edge_num >= MAX_EDGES)
						store_full_seen = 1'b1;
					else begin
						edge_from[edge_num] = int'(src_vertex) - 1;
						edge_to[edge_num] = int'(dst_vertex) - 1;
						edge_num++;
					end
				end
			end
			if (out_valid && out_ready) begin
				if (expected_visits.size() == 0) begin
					$error("result with no expectation: vertex_id %0d", vertex_id);
					errors++;
				end else begin
					want = expected_visits.pop_front();
					if (vertex_id !== want.vid) begin
						$error("vertex_id: expected %0d, got %0d", want.vid, vertex_id);
						errors++;
					end
					if (discovery_time !== want.disc) begin
						$error("discovery_time: expected %0d, got %0d", want.disc,
							discovery_time);
						errors++;
					end
					if (finish_time !== want.fin) begin
						$error("finish_time: expected %0d, got %0d", want.fin, finish_time);
						errors++;
					end
					if (acyclic !== want.acyc) begin
						$error("acyclic: expected %0d, got %0d", want.acyc, acyclic);
						errors++;
					end
					if (edges_dropped !== want.dropped) begin
						$error("edges_dropped: expected %0d, got %0d", want.dropped,
							edges_dropped);
						errors++;
					end
					if (last !== want.lst) begin
						$error("last: expected %0d, got %0d", want.lst, last);
						errors++;
					end
				end
			end
			mismatches <= errors;
			pending <= expected_visits.size();
		end
	end

endmodule

// ===== tb/dfs_timestamps_cycle_detect_tb.sv =====
`timescale 1ns / 1ps

module dfs_timestamps_cycle_detect_tb;
	import dfs_pkg::*;

	// Cycles without any transfer before the run is declared hung. A run with a
	// full edge store reads every edge entry once per vertex before its first result.
	localparam int HANG_LIMIT = 60000;
	// Settling time after the last result: the block clears its colors after a run.
	localparam int SETTLE = 80;

	logic       clk;
	logic       arst_n;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [5:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic       opcode;
	logic [5:0] src_vertex;
	logic [5:0] dst_vertex;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [5:0] vertex_id;
	logic [6:0] discovery_time;
	logic [6:0] finish_time;
	logic       acyclic;
	logic       edges_dropped;
	logic       last;
	int         mismatches;
	int         pending;

	int         idle_pct;
	int         stall_pct;
	int         items_sent;
	int         quiet_cycles = 0;

	dfs_timestamps_cycle_detect uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.src_vertex(src_vertex), .dst_vertex(dst_vertex),
		.out_valid(out_valid), .out_ready(out_ready), .vertex_id(vertex_id),
		.discovery_time(discovery_time), .finish_time(finish_time),
		.acyclic(acyclic), .edges_dropped(edges_dropped), .last(last)
	);

	dfs_search_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.src_vertex(src_vertex), .dst_vertex(dst_vertex),
		.out_valid(out_valid), .out_ready(out_ready), .vertex_id(vertex_id),
		.discovery_time(discovery_time), .finish_time(finish_time),
		.acyclic(acyclic), .edges_dropped(edges_dropped), .last(last),
		.mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver drops ready at random, at the rate set for the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: counts cycles in which no transfer happens on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Sends one input item. A random gap may come first; valid is only lowered
	// when a gap follows, so it stays high across back-to-back transfers.
	task automatic send_item(input logic op, input logic [5:0] s, input logic [5:0] d);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		src_vertex <= s;
		dst_vertex <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic add_edge(input logic [5:0] s, input logic [5:0] d);
		send_item(OP_ADD, s, d);
	endtask

	task automatic run_search();
		send_item(OP_RUN, 6'($urandom), 6'($urandom));
	endtask

	// Waits until every expected result has arrived and the block has cleared.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Writes vertex_count; only called once the block is idle.
	task automatic set_vertex_count(input logic [5:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_pace(input int phase);
		case (phase % 4)
			0: begin idle_pct = 0;  stall_pct = 0;  end
			1: begin idle_pct = 52; stall_pct = 0;  end
			2: begin idle_pct = 0;  stall_pct = 52; end
			default: begin idle_pct = 6; stall_pct = 6; end
		endcase
	endtask

	// A vertex outside 1..32: zero or something from 33 up to 63.
	function automatic logic [5:0] bad_vertex();
		return ($urandom_range(1) == 0) ? 6'd0 : 6'($urandom_range(63, 33));
	endfunction

	initial begin
		int n;
		int edges;
		int mode;
		int phase;
		logic [5:0] s;
		logic [5:0] d;
		logic [5:0] cfg_pick;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 6'd0;
		in_valid = 1'b0;
		opcode = OP_ADD;
		src_vertex = 6'd0;
		dst_vertex = 6'd0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, using the reset vertex count of 32: a three-vertex cycle,
		// a self-loop, edges touching the top vertex, and edges with vertices out
		// of range that must be ignored.
		add_edge(6'd1, 6'd2);
		add_edge(6'd2, 6'd3);
		add_edge(6'd3, 6'd1);
		add_edge(6'd4, 6'd4);
		add_edge(6'd32, 6'd1);
		add_edge(6'd5, 6'd32);
		add_edge(6'd0, 6'd5);
		add_edge(6'd33, 6'd1);
		add_edge(6'd5, 6'd63);
		add_edge(6'd63, 6'd0);
		run_search();
		wait_drained();

		// A count of zero acts as one; the edge to vertex 2 lies beyond it.
		set_vertex_count(6'd0);
		add_edge(6'd1, 6'd2);
		add_edge(6'd2, 6'd1);
		run_search();
		wait_drained();

		// One vertex with a self-loop is cyclic.
		set_vertex_count(6'd1);
		add_edge(6'd1, 6'd1);
		run_search();
		wait_drained();

		// A count above the maximum acts as 32; a chain gives the deepest stack.
		set_vertex_count(6'd63);
		for (int i = 1; i < 32; i++)
			add_edge(6'(i), 6'(i + 1));
		run_search();
		wait_drained();

		// Random part: each phase changes the pace, sometimes the vertex count,
		// then loads a graph and runs the search.
		phase = 0;
		while (items_sent < 430) begin
			set_pace(phase);
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(5))
					0: cfg_pick = 6'd1;
					1: cfg_pick = 6'd32;
					2: cfg_pick = 6'd0;
					3: cfg_pick = 6'($urandom_range(63, 33));
					default: cfg_pick = 6'($urandom_range(31, 2));
				endcase
				set_vertex_count(cfg_pick);
			end else
				cfg_pick = chk.vertex_limit;
			n = (cfg_pick == 0) ? 1 : (cfg_pick > 32 ? 32 : int'(cfg_pick));
			mode = $urandom_range(9);
			if (phase == 3) begin
				// Overfill the edge store so that some edges are dropped.
				set_vertex_count(6'd32);
				n = 32;
				edges = 262;
			end else
				edges = $urandom_range(24);
			for (int i = 0; i < edges; i++) begin
				s = 6'($urandom_range(n, 1));
				d = 6'($urandom_range(n, 1));
				// Mostly forward edges for an acyclic graph, at times anything at all.
				if (mode < 5 && s > d) begin
					s ^= d;
					d ^= s;
					s ^= d;
				end
				if (mode < 5 && s == d)
					d = (s < 6'(n)) ? s + 6'd1 : 6'(n);
				// The overfill phase keeps every edge in range so the store does fill.
				if (phase != 3 && $urandom_range(9) == 0)
					s = bad_vertex();
				if (phase != 3 && $urandom_range(9) == 0)
					d = bad_vertex();
				if (n > 1 && mode < 5 && s == d && s >= 1 && s <= 32)
					continue;
				add_edge(s, d);
			end
			run_search();
			wait_drained();
			phase++;
		end

		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
src/dfs_pkg.sv
src/dfs_timestamps_cycle_detect.sv
tb/dfs_search_checker.sv
tb/dfs_timestamps_cycle_detect_tb.sv
